>>> src/ssp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the servo slew pulse controller: payload
// structs, register and operation codes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int DEFAULT_CHANNELS = 2;

	localparam int OP_W    = 2;
	localparam int CH_W    = 3;
	localparam int TGT_W   = 20;
	localparam int DT_W    = 16;
	localparam int ANGLE_W = 19;
	localparam int PULSE_W = 15;
	localparam int SLEW_W  = 14;

	// pulse map divider: 38-bit dividend, 20-bit divisor
	localparam int DIV_NW = 38;
	localparam int DIV_DW = 20;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [ANGLE_W-1:0] CENTRE_MDEG      = 19'd90000;
	localparam logic [ANGLE_W-1:0] ANGLE_MIN_RESET  = 19'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_RESET  = 19'd180000;
	localparam logic [PULSE_W-1:0] PULSE_MIN_RESET  = 15'd500;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RESET  = 15'd2500;
	localparam logic [SLEW_W-1:0]  SLEW_RESET       = 14'd360;
	localparam logic [PULSE_W-1:0] PULSE_CAP        = 15'd20000;
	// half of the millidegree-per-microsecond scale, for round half up
	localparam logic [9:0]         STEP_HALF        = 10'd500;
	// divide by 125 after a shift by three: ceil(2^35 / 125), exact below 2^28
	localparam int                 STEP_SHIFT       = 35;
	localparam logic [28:0]        STEP_RECIP       = 29'd274877907;

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 2'd0,
		OP_JUMP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ANGLE_MIN = 3'd0,
		REG_ANGLE_MAX = 3'd1,
		REG_PULSE_MIN = 3'd2,
		REG_PULSE_MAX = 3'd3,
		REG_SLEW      = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SET,
		S_STEP,
		S_MOVE,
		S_MUL,
		S_PDIV,
		S_PWAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic [CH_W-1:0]          channel;
		logic signed [TGT_W-1:0]  target_mdeg;
		logic [DT_W-1:0]          dt_us;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic [PULSE_W-1:0] pulse_us;
		logic [ANGLE_W-1:0] angle_mdeg;
		logic [ANGLE_W-1:0] goal_mdeg;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_min_mdeg;
		logic [ANGLE_W-1:0] angle_max_mdeg;
		logic [PULSE_W-1:0] pulse_min_us;
		logic [PULSE_W-1:0] pulse_max_us;
		logic [SLEW_W-1:0]  slew_deg_per_s;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic set_write;
		logic step_start;
		logic step_latch;
		logic move;
		logic mul;
		logic pulse_start;
		logic emit;
		logic next;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic ch_valid;
		logic dt_zero;
		logic div_done;
		logic idx_last;
	} status_t;

endpackage
`default_nettype wire

>>> src/servo_slew_pulse_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_pulse_controller
// Per-channel angle and target store with slew-limited ticks and an
// angle-to-pulse-width map, behind a start/busy command port.
//
// An item is taken at a clock edge with start high and busy low; busy then
// stays high until the item is finished. Results are shown on result for one
// cycle each, marked by result_valid, and cannot be held off; result.last
// flags the final one of an item. busy is low in the cycle of a final result.
// Each pulse is set by the one-bit-per-cycle 38-bit divider, which holds the
// sequencer until the division is done. Per kind of item:
//   set target: clamp and store, no result
//   invalid set or jump, zero-dt tick: no result
//   jump: clamp and store, one result; valid query: one result
//   invalid query: one result with zero fields
//   tick: one result per channel in order
// Configuration is to be written through the APB port only while the block
// is idle; the block itself does not enforce this. Reads return the stored
// register value. Reset restores the default range, pulse map and slew
// rate, and puts every channel's angle and target at the centre.
// ----------------------------------------------------------------------------
module servo_slew_pulse_controller #(
	parameter int CHANNELS = ssp_pkg::DEFAULT_CHANNELS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  ssp_pkg::item_t             item,
	output logic                       result_valid,
	output ssp_pkg::result_t           result,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [ssp_pkg::ADDR_W-1:0]  paddr,
	input  wire [ssp_pkg::DATA_W-1:0]  pwdata,
	output logic [ssp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import ssp_pkg::*;

	cfg_t     cfg_q;
	cmd_t     cmd;
	status_t  status;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_min_mdeg <= ANGLE_MIN_RESET;
			cfg_q.angle_max_mdeg <= ANGLE_MAX_RESET;
			cfg_q.pulse_min_us   <= PULSE_MIN_RESET;
			cfg_q.pulse_max_us   <= PULSE_MAX_RESET;
			cfg_q.slew_deg_per_s <= SLEW_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ANGLE_MIN: cfg_q.angle_min_mdeg <= pwdata[ANGLE_W-1:0];
				REG_ANGLE_MAX: cfg_q.angle_max_mdeg <= pwdata[ANGLE_W-1:0];
				REG_PULSE_MIN: cfg_q.pulse_min_us   <= pwdata[PULSE_W-1:0];
				REG_PULSE_MAX: cfg_q.pulse_max_us   <= pwdata[PULSE_W-1:0];
				REG_SLEW:      cfg_q.slew_deg_per_s <= pwdata[SLEW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ANGLE_MIN: prdata = DATA_W'(cfg_q.angle_min_mdeg);
			REG_ANGLE_MAX: prdata = DATA_W'(cfg_q.angle_max_mdeg);
			REG_PULSE_MIN: prdata = DATA_W'(cfg_q.pulse_min_us);
			REG_PULSE_MAX: prdata = DATA_W'(cfg_q.pulse_max_us);
			REG_SLEW:      prdata = DATA_W'(cfg_q.slew_deg_per_s);
			default:       prdata = '0;
		endcase
	end

	ssp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssp_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> src/ssp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_div
// Restoring unsigned divider, one quotient bit per cycle. Quotient stays
// valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module ssp_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [ssp_pkg::DIV_NW-1:0]  numer,
	input  wire [ssp_pkg::DIV_DW-1:0]  divisor,
	output logic                       done,
	output logic [ssp_pkg::DIV_NW-1:0] quotient
);
	import ssp_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_NW-1:0] quo_q;

	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		fits  = trial >= {1'b0, d_q};
		diff  = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			quo_q <= numer;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> src/ssp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_datapath
// Angle state, clamp, slew step, pulse map multiply and divide, and the
// result register. Driven by the controller through a command group.
// ----------------------------------------------------------------------------
module ssp_datapath #(
	parameter int CHANNELS = ssp_pkg::DEFAULT_CHANNELS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  ssp_pkg::cfg_t      cfg,
	input  ssp_pkg::item_t     item,
	input  ssp_pkg::cmd_t      cmd,
	output ssp_pkg::status_t   status,
	output logic               result_valid,
	output ssp_pkg::result_t   result
);
	import ssp_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MUL_W = 36;
	localparam int US_W  = DIV_NW + 2;

	op_t                     op_q;
	logic [CH_W-1:0]         ch_q;
	logic signed [TGT_W-1:0] tgt_q;
	logic [DT_W-1:0]         dt_q;
	logic [IDX_W-1:0]        idx_q;
	logic [30:0]             step_sum_q;
	logic [20:0]             step_q;
	logic signed [MUL_W-1:0] prod_q;
	logic                    neg_q;

	logic [ANGLE_W-1:0] cur_q [CHANNELS];
	logic [ANGLE_W-1:0] goal_q [CHANNELS];

	logic                    valid_q;
	result_t                 result_q;

	logic                    ch_valid;
	logic                    idx_last;
	logic [ANGLE_W-1:0]      cur;
	logic [ANGLE_W-1:0]      goal;
	logic [ANGLE_W-1:0]      clamped;
	logic signed [TGT_W:0]   tgt_ext;
	logic signed [21:0]      remain;
	logic signed [21:0]      stp;
	logic [ANGLE_W-1:0]      moved;
	logic signed [19:0]      diff;
	logic signed [15:0]      span;
	logic signed [19:0]      den;
	logic                    span_empty;
	logic signed [DIV_NW-1:0] pnum;
	logic [DIV_NW-1:0]       pmag;
	logic [29:0]             slew_dt;
	logic [30:0]             step_sum;
	logic [56:0]             step_prod;
	logic                    div_start;
	logic [DIV_NW-1:0]       div_numer;
	logic [DIV_DW-1:0]       div_divisor;
	logic                    div_done;
	logic [DIV_NW-1:0]       quo;
	logic signed [DIV_NW:0]  qs;
	logic signed [US_W-1:0]  us;
	logic [PULSE_W-1:0]      pulse;
	result_t                 res_next;

	assign ch_valid = {1'b0, ch_q} < (CH_W + 1)'(CHANNELS);
	assign idx_last = idx_q == IDX_W'(CHANNELS - 1);
	assign cur      = cur_q[idx_q];
	assign goal     = goal_q[idx_q];

	// clamp tests the minimum first
	always_comb begin
		tgt_ext = {tgt_q[TGT_W-1], tgt_q};
		if (tgt_ext < $signed({2'b00, cfg.angle_min_mdeg}))
			clamped = cfg.angle_min_mdeg;
		else if (tgt_ext > $signed({2'b00, cfg.angle_max_mdeg}))
			clamped = cfg.angle_max_mdeg;
		else
			clamped = tgt_q[ANGLE_W-1:0];
	end

	// slew move toward the goal
	always_comb begin
		remain = $signed({3'b000, goal}) - $signed({3'b000, cur});
		stp    = $signed({1'b0, step_q});
		if (remain > stp)
			moved = cur + step_q[ANGLE_W-1:0];
		else if (remain < -stp)
			moved = cur - step_q[ANGLE_W-1:0];
		else
			moved = goal;
	end

	// pulse map operands
	always_comb begin
		diff       = $signed({1'b0, cur}) - $signed({1'b0, cfg.angle_min_mdeg});
		span       = $signed({1'b0, cfg.pulse_max_us}) - $signed({1'b0, cfg.pulse_min_us});
		den        = $signed({1'b0, cfg.angle_max_mdeg}) -
		             $signed({1'b0, cfg.angle_min_mdeg});
		span_empty = den[19] || (den == 20'sd0);
		pnum       = $signed({prod_q[MUL_W-1], prod_q, 1'b0}) +
		             $signed({{(DIV_NW-20){den[19]}}, den});
		// floor of a negative quotient: divide the one's complement, invert back
		pmag       = pnum[DIV_NW-1] ? ~pnum : pnum;
	end

	always_comb begin
		slew_dt   = cfg.slew_deg_per_s * dt_q;
		step_sum  = {1'b0, slew_dt} + {21'd0, STEP_HALF};
		// divide by 1000 as a shift by three and a reciprocal multiply for 125
		step_prod = step_sum_q[30:3] * STEP_RECIP;
	end

	assign div_start   = cmd.pulse_start;
	assign div_numer   = pmag;
	assign div_divisor = {den[18:0], 1'b0};

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		qs = neg_q ? ~$signed({1'b0, quo}) : $signed({1'b0, quo});
		us = $signed({{(US_W-PULSE_W){1'b0}}, cfg.pulse_min_us}) + $signed({qs[DIV_NW], qs});
		if (span_empty)
			pulse = (cfg.pulse_min_us > PULSE_CAP) ? PULSE_CAP : cfg.pulse_min_us;
		else if (us[US_W-1])
			pulse = '0;
		else if (us > $signed({{(US_W-PULSE_W){1'b0}}, PULSE_CAP}))
			pulse = PULSE_CAP;
		else
			pulse = us[PULSE_W-1:0];
	end

	always_comb begin
		res_next.last = (op_q != OP_TICK) || idx_last;
		if (op_q == OP_QUERY && !ch_valid) begin
			res_next.out_channel = ch_q;
			res_next.pulse_us    = '0;
			res_next.angle_mdeg  = '0;
			res_next.goal_mdeg   = '0;
		end else begin
			res_next.out_channel = (op_q == OP_TICK) ? CH_W'(idx_q) : ch_q;
			res_next.pulse_us    = pulse;
			res_next.angle_mdeg  = cur;
			res_next.goal_mdeg   = goal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i]  <= CENTRE_MDEG;
				goal_q[i] <= CENTRE_MDEG;
			end
			valid_q <= 1'b0;
			op_q    <= OP_SET;
			idx_q   <= '0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load) begin
				op_q  <= item.op;
				idx_q <= item.channel[IDX_W-1:0];
			end
			if (cmd.step_latch)
				idx_q <= '0;
			if (cmd.next)
				idx_q <= idx_q + 1'b1;
			if (cmd.set_write) begin
				goal_q[idx_q] <= clamped;
				if (op_q == OP_JUMP)
					cur_q[idx_q] <= clamped;
			end
			if (cmd.move)
				cur_q[idx_q] <= moved;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= item.channel;
			tgt_q <= item.target_mdeg;
			dt_q  <= item.dt_us;
		end
		if (cmd.step_start)
			step_sum_q <= step_sum;
		if (cmd.step_latch)
			step_q <= step_prod[STEP_SHIFT+20:STEP_SHIFT];
		if (cmd.mul)
			prod_q <= diff * span;
		if (cmd.pulse_start)
			neg_q <= pnum[DIV_NW-1];
		if (cmd.emit)
			result_q <= res_next;
	end

	always_comb begin
		status.op       = op_q;
		status.ch_valid = ch_valid;
		status.dt_zero  = (dt_q == '0);
		status.div_done = div_done;
		status.idx_last = idx_last;
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

>>> src/ssp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer for one operation at a time: decode, clamp and store, slew step
// scaling, per-channel move, multiply, divide and emit.
// ----------------------------------------------------------------------------
module ssp_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  ssp_pkg::status_t  status,
	output ssp_pkg::cmd_t     cmd,
	output logic              busy
);
	import ssp_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.op)
					OP_SET, OP_JUMP: begin
						state_next = status.ch_valid ? S_SET : S_IDLE;
					end
					OP_TICK: begin
						if (status.dt_zero) begin
							state_next = S_IDLE;
						end else begin
							cmd.step_start = 1'b1;
							state_next     = S_STEP;
						end
					end
					default: begin
						state_next = status.ch_valid ? S_MUL : S_EMIT;
					end
				endcase
			end
			S_SET: begin
				cmd.set_write = 1'b1;
				state_next    = (status.op == OP_JUMP) ? S_MUL : S_IDLE;
			end
			S_STEP: begin
				cmd.step_latch = 1'b1;
				state_next     = S_MOVE;
			end
			S_MOVE: begin
				cmd.move   = 1'b1;
				state_next = S_MUL;
			end
			S_MUL: begin
				cmd.mul    = 1'b1;
				state_next = S_PDIV;
			end
			S_PDIV: begin
				cmd.pulse_start = 1'b1;
				state_next      = S_PWAIT;
			end
			S_PWAIT: begin
				if (status.div_done)
					state_next = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (status.op == OP_TICK && !status.idx_last) begin
					cmd.next   = 1'b1;
					state_next = S_MOVE;
				end else begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> src/ssp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
module ssp_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               result_valid,
	input ssp_pkg::result_t  result
);
	import ssp_pkg::*;

	// an accepted item holds the port busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted item");

	// no result in the cycle right after a transfer in
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid)
		else $error("result right after accepted item");

	// the final result ends the item
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy still high on final result");

	// more results follow a non-final one
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("idle while results pending");

	// results of one tick are spaced by the per-channel work
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> !result_valid)
		else $error("back-to-back results within a tick");

endmodule

bind servo_slew_pulse_controller ssp_checker u_ssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire
